### rtl/pfb_pkg.sv
// Shared constants, types and helpers for the paged framebuffer.
package pfb_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int PAGE_COUNT   = 8;
  localparam int SCROLL_COLS  = 4;
  localparam int COL_W        = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W       = $clog2(PAGE_COUNT);
  localparam int ADDR_W       = COL_W + PAGE_W;
  localparam int STORE_BYTES  = SCREEN_WIDTH * PAGE_COUNT;

  localparam logic [2:0] CMD_DRAW   = 3'd0;
  localparam logic [2:0] CMD_DOWN   = 3'd1;
  localparam logic [2:0] CMD_LEFT   = 3'd2;
  localparam logic [2:0] CMD_RIGHT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  localparam logic [1:0] MODE_2X2 = 2'd0;
  localparam logic [1:0] MODE_2X1 = 2'd1;

  typedef enum logic [2:0] {
    OP_DRAW, OP_DOWN, OP_LEFT, OP_RIGHT, OP_CLEAR, OP_READ, OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DRAW0, ST_DRAW1, ST_DRAW2, ST_READ0, ST_READ1,
    ST_MOVE0, ST_MOVE1, ST_MOVE2, ST_CLEAR
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    logic              dbl_w;
    logic              dbl_h;
    logic              value;
    logic [2:0]        skip;
    logic [2:0]        shift;
  } job_t;

  typedef struct packed {
    logic collision;
    logic [7:0] read_data;
  } result_t;

  function automatic logic [7:0] apply_mask(logic [7:0] b, logic [7:0] m, logic on);
    return on ? (b | m) : (b & ~m);
  endfunction

endpackage

### rtl/paged_framebuffer_xor_scroll.sv
// Top level of the paged XOR framebuffer with scrolling.
// Usage:
//   Commands enter through push/full; one transaction is taken when push is
//   high and full is low. Each command yields exactly one result on the
//   collision/read_data ports, shown while empty is low and taken by pop.
//   pixel_mode is written through cfg_valid/cfg_ready/cfg_data (always ready).
// Sequencing (one command at a time in the store sequencer):
//   a draw updates its byte (and its odd partner in wide modes), a read
//   reads one byte, unused commands answer from idle, a clear zeroes all
//   1024 bytes; scrolls left/right/down do two reads and one write per byte.
//   A two-entry job queue and a two-entry result queue decouple the sides.
// Reset:
//   The store is zeroed by a pass over all 1024 bytes; full stays high meanwhile.
// Stall:
//   When results are not popped the result queue fills, the sequencer
//   holds, then the job queue fills and full rises.
module paged_framebuffer_xor_scroll (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [2:0] command,
  input  logic [6:0] pixel_x,
  input  logic [5:0] pixel_y,
  input  logic       draw_value,
  input  logic [5:0] scroll_rows,
  input  logic [9:0] byte_index,
  output logic       empty,
  input  logic       pop,
  output logic       collision,
  output logic [7:0] read_data
);
  import pfb_pkg::*;

  logic job_valid, job_take, init_busy;
  job_t job;

  pfb_front u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full), .command(command), .pixel_x(pixel_x),
    .pixel_y(pixel_y), .draw_value(draw_value), .scroll_rows(scroll_rows),
    .byte_index(byte_index), .init_busy(init_busy),
    .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  pfb_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job(job), .job_take(job_take),
    .init_busy(init_busy), .pop(pop), .empty(empty),
    .collision(collision), .read_data(read_data)
  );

endmodule

### rtl/pfb_ram.sv
// Generic simple dual-port RAM with registered read.
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pfb_front.sv
// Front end: mode register, command decode and job queue.
module pfb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        command,
  input  logic [6:0]        pixel_x,
  input  logic [5:0]        pixel_y,
  input  logic              draw_value,
  input  logic [5:0]        scroll_rows,
  input  logic [9:0]        byte_index,
  input  logic              init_busy,
  output logic              job_valid,
  output pfb_pkg::job_t     job,
  input  logic              job_take
);
  import pfb_pkg::*;

  logic [1:0] pixel_mode;
  job_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  job_t       dec;
  logic       accept;
  logic [6:0] xs;
  logic [5:0] ys;

  assign cfg_ready = 1'b1;
  assign full      = (cnt == 2'd2) || init_busy;
  assign accept    = push && !full;
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  always_comb begin
    dec = '0;
    dec.dbl_w = (pixel_mode == MODE_2X2) || (pixel_mode == MODE_2X1);
    dec.dbl_h = (pixel_mode == MODE_2X2);
    xs = dec.dbl_w ? {pixel_x[5:0], 1'b0} : pixel_x;
    ys = dec.dbl_h ? {pixel_y[4:0], 1'b0} : pixel_y;
    dec.value   = draw_value;
    dec.bit_sel = ys[2:0];
    dec.skip    = scroll_rows[5:3];
    dec.shift   = scroll_rows[2:0];
    dec.addr    = {ys[5:3], xs};
    case (command)
      CMD_DRAW:  dec.op = OP_DRAW;
      CMD_DOWN:  dec.op = OP_DOWN;
      CMD_LEFT:  dec.op = OP_LEFT;
      CMD_RIGHT: dec.op = OP_RIGHT;
      CMD_CLEAR: dec.op = OP_CLEAR;
      CMD_READ: begin
        dec.op   = OP_READ;
        dec.addr = byte_index;
      end
      default:   dec.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= MODE_2X2;
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (cfg_valid) begin
        pixel_mode <= cfg_data;
      end
      if (accept) begin
        wp <= ~wp;
      end
      if (job_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(accept) - 2'(job_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wp] <= dec;
    end
  end

endmodule

### rtl/pfb_back.sv
// Back end: frame store sequencer and result queue.
module pfb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  pfb_pkg::job_t job,
  output logic          job_take,
  output logic          init_busy,
  input  logic          pop,
  output logic          empty,
  output logic          collision,
  output logic [7:0]    read_data
);
  import pfb_pkg::*;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(STORE_BYTES - 1);

  state_t            state, state_next;
  job_t              cur;
  logic [ADDR_W-1:0] k;
  logic [7:0]        a_byte;
  logic              was, on;
  result_t           rq [2];
  logic              rwp, rrp;
  logic [1:0]        rcnt;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;
  logic              res_push;
  result_t           res;

  logic [PAGE_W-1:0] pg, pa;
  logic [COL_W-1:0]  col;
  logic [2:0]        sh;
  logic              aval, bval, k_last, on_now;
  logic [ADDR_W-1:0] src_a, src_b;
  logic [7:0]        m1, mask;

  pfb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign init_busy = (state == ST_INIT);
  assign job_take  = (state == ST_IDLE) && job_valid && (rcnt != 2'd2);
  assign empty     = (rcnt == 2'd0);
  assign collision = rq[rrp].collision;
  assign read_data = rq[rrp].read_data;

  always_comb begin
    pg  = k[ADDR_W-1:COL_W];
    col = k[COL_W-1:0];
    pa  = pg - PAGE_W'(cur.skip);
    sh  = (cur.op == OP_DOWN) ? cur.shift : 3'd0;
    src_b = {pa - PAGE_W'(1), col};
    bval  = 1'b0;
    case (cur.op)
      OP_LEFT: begin
        aval  = col < COL_W'(SCREEN_WIDTH - SCROLL_COLS);
        src_a = k + ADDR_W'(SCROLL_COLS);
      end
      OP_RIGHT: begin
        aval  = col >= COL_W'(SCROLL_COLS);
        src_a = k - ADDR_W'(SCROLL_COLS);
      end
      default: begin
        aval  = {1'b0, pg} >= {1'b0, PAGE_W'(cur.skip)};
        bval  = (sh != 3'd0) && ({1'b0, pg} > {1'b0, PAGE_W'(cur.skip)});
        src_a = {pa, col};
      end
    endcase
    k_last = (cur.op == OP_LEFT || state == ST_CLEAR || state == ST_INIT) ?
             (k == LAST) : (k == '0);
    m1     = 8'd1 << cur.bit_sel;
    mask   = m1 | (cur.dbl_h ? (m1 << 1) : 8'd0);
    on_now = rdata[cur.bit_sel] ^ cur.value;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (k == LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (job_take) begin
          case (job.op)
            OP_DRAW:  state_next = ST_DRAW0;
            OP_READ:  state_next = ST_READ0;
            OP_CLEAR: state_next = ST_CLEAR;
            OP_NOP:   state_next = ST_IDLE;
            default:  state_next = ST_MOVE0;
          endcase
        end
      end
      ST_DRAW0: state_next = ST_DRAW1;
      ST_DRAW1: state_next = ST_DRAW2;
      ST_DRAW2: state_next = ST_IDLE;
      ST_READ0: state_next = ST_READ1;
      ST_READ1: state_next = ST_IDLE;
      ST_MOVE0: state_next = ST_MOVE1;
      ST_MOVE1: state_next = ST_MOVE2;
      ST_MOVE2: state_next = k_last ? ST_IDLE : ST_MOVE0;
      ST_CLEAR: if (k_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = k;
    wdata = 8'd0;
    raddr = cur.addr;
    res_push = 1'b0;
    res = '0;
    case (state)
      ST_INIT: we = 1'b1;
      ST_IDLE: res_push = job_take && (job.op == OP_NOP);
      ST_DRAW1: begin
        raddr = {cur.addr[ADDR_W-1:1], 1'b1};
        we    = 1'b1;
        waddr = cur.addr;
        wdata = apply_mask(rdata, mask, on_now);
      end
      ST_DRAW2: begin
        we    = cur.dbl_w;
        waddr = {cur.addr[ADDR_W-1:1], 1'b1};
        wdata = apply_mask(rdata, mask, on);
        res_push = 1'b1;
        res.collision = was && cur.value;
      end
      ST_READ1: begin
        res_push = 1'b1;
        res.read_data = rdata;
      end
      ST_MOVE0: raddr = src_a;
      ST_MOVE1: raddr = src_b;
      ST_MOVE2: begin
        we = 1'b1;
        wdata = (aval ? (a_byte << sh) : 8'd0) |
                (bval ? (rdata >> (4'd8 - {1'b0, sh})) : 8'd0);
        res_push = k_last;
      end
      ST_CLEAR: begin
        we = 1'b1;
        res_push = k_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      k     <= '0;
      rwp   <= 1'b0;
      rrp   <= 1'b0;
      rcnt  <= 2'd0;
    end else begin
      state <= state_next;
      if (res_push) begin
        rwp <= ~rwp;
      end
      if (pop && !empty) begin
        rrp <= ~rrp;
      end
      rcnt <= rcnt + 2'(res_push) - 2'(pop && !empty);
      case (state)
        ST_INIT, ST_CLEAR: k <= k + ADDR_W'(1);
        ST_IDLE: k <= (job.op == OP_RIGHT || job.op == OP_DOWN) ? LAST : '0;
        ST_MOVE2: k <= (cur.op == OP_LEFT) ? k + ADDR_W'(1) : k - ADDR_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
    if (state == ST_MOVE1) begin
      a_byte <= rdata;
    end
    if (state == ST_DRAW1) begin
      was <= rdata[cur.bit_sel];
      on  <= on_now;
    end
    if (res_push) begin
      rq[rwp] <= res;
    end
  end

  a_rcnt_bound: assert property (@(posedge clk) disable iff (rst) rcnt <= 2'd2)
    else $error("result queue overflow");
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (rcnt != 2'd2))
    else $error("result pushed into full queue");
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> !res_push && !job_take)
    else $error("activity during clearing pass");
  a_reset_init: assert property (@(posedge clk) $past(rst) |-> state == ST_INIT)
    else $error("reset did not start clearing pass");

endmodule

### tb/tb.sv
// Self-checking testbench for the paged XOR framebuffer with scrolling.
module tb;
  import pfb_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [1:0] MODE_1X1   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = '0;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] command = '0;
  logic [6:0] pixel_x = '0;
  logic [5:0] pixel_y = '0;
  logic       draw_value = 1'b0;
  logic [5:0] scroll_rows = '0;
  logic [9:0] byte_index = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic       collision;
  logic [7:0] read_data;

  paged_framebuffer_xor_scroll u_top (.*);

  logic [7:0] frame_img [STORE_BYTES];
  logic [1:0] mode_reg;
  result_t    want_q [$];
  int         cycles, mismatches, strays, sent, checked, scrolls, draws;
  bit         steady;
  int         last_addr;

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("paged_framebuffer_xor_scroll regression: fail");
      $finish;
    end
  end

  function automatic result_t predict_cmd(logic [2:0] c, logic [6:0] cx, logic [5:0] cy,
                                          logic v, logic [5:0] rows, logic [9:0] idx);
    result_t    r;
    logic [7:0] prev [STORE_BYTES];
    int sw, sh, x, y, a, skip, sft, src;
    logic was, on;
    r = '0;
    prev = frame_img;
    case (c)
      CMD_DRAW: begin
        sw = (mode_reg < MODE_1X1) ? 2 : 1;
        sh = (mode_reg == MODE_2X2) ? 2 : 1;
        x = (sw * cx) % SCREEN_WIDTH;
        y = (sh * cy) % (PAGE_COUNT * 8);
        last_addr = (y / 8) * SCREEN_WIDTH + x;
        was = frame_img[last_addr][y % 8];
        on = was ^ v;
        for (int j = 0; j < sh; j++)
          for (int i = 0; i < sw; i++)
            if (x + i < SCREEN_WIDTH && y + j < PAGE_COUNT * 8) begin
              a = ((y + j) / 8) * SCREEN_WIDTH + x + i;
              frame_img[a][(y + j) % 8] = on;
            end
        r.collision = was & ~on;
      end
      CMD_DOWN: begin
        skip = rows / 8;
        sft = rows % 8;
        for (int p = 0; p < PAGE_COUNT; p++)
          for (int col = 0; col < SCREEN_WIDTH; col++) begin
            a = p * SCREEN_WIDTH + col;
            frame_img[a] = '0;
            if (p >= skip) begin
              src = (p - skip) * SCREEN_WIDTH + col;
              frame_img[a] = prev[src] << sft;
              if (sft != 0 && p > skip)
                frame_img[a] |= prev[src - SCREEN_WIDTH] >> (8 - sft);
            end
          end
      end
      CMD_LEFT, CMD_RIGHT: begin
        for (int p = 0; p < PAGE_COUNT; p++)
          for (int col = 0; col < SCREEN_WIDTH; col++) begin
            src = (c == CMD_LEFT) ? col + SCROLL_COLS : col - SCROLL_COLS;
            frame_img[p * SCREEN_WIDTH + col] = (src < 0 || src >= SCREEN_WIDTH) ?
                8'd0 : prev[p * SCREEN_WIDTH + src];
          end
      end
      CMD_CLEAR: foreach (frame_img[k]) frame_img[k] = '0;
      CMD_READ: r.read_data = (idx < STORE_BYTES) ? frame_img[idx] : 8'd0;
      default: ;
    endcase
    return r;
  endfunction

  // Result side: random stalls, checked at the rising edge.
  always @(negedge clk) pop <= steady ? 1'b1 : ($urandom_range(99) >= 7);

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      checked++;
      if (want_q.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        result_t w;
        w = want_q.pop_front();
        if (w.collision !== collision || w.read_data !== read_data) begin
          mismatches++;
          if (mismatches + strays <= 10)
            $display("mismatch: expected coll=%0b data=%02h, got coll=%0b data=%02h",
                     w.collision, w.read_data, collision, read_data);
        end
      end
    end
  end

  task automatic send_cmd(logic [2:0] c, logic [6:0] cx, logic [5:0] cy, logic v,
                          logic [5:0] rows, logic [9:0] idx);
    while (!steady && $urandom_range(99) < 7) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    command = c; pixel_x = cx; pixel_y = cy;
    draw_value = v; scroll_rows = rows; byte_index = idx;
    do @(posedge clk); while (full);
    want_q.push_back(predict_cmd(c, cx, cy, v, rows, idx));
    sent++;
    if (c == CMD_DRAW) draws++;
    if (c inside {CMD_DOWN, CMD_LEFT, CMD_RIGHT}) scrolls++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic drain;
    while (want_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    repeat (8) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = m;
    do @(posedge clk); while (!cfg_ready);
    mode_reg = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random;
    int pick;
    logic [2:0] c;
    logic [9:0] idx;
    pick = $urandom_range(999);
    if (pick < 600) c = CMD_DRAW;
    else if (pick < 960) c = CMD_READ;
    else if (pick < 970) c = CMD_DOWN;
    else if (pick < 976) c = CMD_LEFT;
    else if (pick < 982) c = CMD_RIGHT;
    else if (pick < 986) c = CMD_CLEAR;
    else c = pick[0] ? CMD_SPARE7 : CMD_SPARE6;
    idx = 10'($urandom());
    if (c == CMD_READ && $urandom_range(1)) idx = 10'(last_addr);
    send_cmd(c, 7'($urandom()), 6'($urandom()), 1'($urandom()), 6'($urandom()), idx);
  endtask

  task automatic test_directed(logic [1:0] m);
    write_mode(m);
    send_cmd(CMD_DRAW, 7'd0, 6'd0, 1'b1, 6'd0, 10'd0);
    send_cmd(CMD_READ, 7'd0, 6'd0, 1'b0, 6'd0, 10'd0);
    send_cmd(CMD_DRAW, 7'd127, 6'd63, 1'b1, 6'd63, 10'd1023);
    send_cmd(CMD_READ, 7'd0, 6'd0, 1'b0, 6'd0, 10'd1023);
    send_cmd(CMD_READ, 7'd0, 6'd0, 1'b0, 6'd0, 10'd127);
    send_cmd(CMD_DRAW, 7'd63, 6'd31, 1'b1, 6'd0, 10'd0);
    send_cmd(CMD_DRAW, 7'd63, 6'd31, 1'b0, 6'd0, 10'd0);
    send_cmd(CMD_DRAW, 7'd63, 6'd31, 1'b1, 6'd0, 10'd0);
    send_cmd(CMD_DRAW, 7'd0, 6'd0, 1'b1, 6'd0, 10'd0);
    send_cmd(CMD_DRAW, 7'd5, 6'd3, 1'b1, 6'd0, 10'd0);
    send_cmd(CMD_DOWN, 7'd0, 6'd0, 1'b0, 6'd9, 10'd0);
    send_cmd(CMD_READ, 7'd0, 6'd0, 1'b0, 6'd0, 10'd138);
    send_cmd(CMD_LEFT, 7'd0, 6'd0, 1'b0, 6'd0, 10'd0);
    send_cmd(CMD_RIGHT, 7'd0, 6'd0, 1'b0, 6'd0, 10'd0);
    send_cmd(CMD_READ, 7'd0, 6'd0, 1'b0, 6'd0, 10'd384);
    send_cmd(CMD_SPARE6, 7'd127, 6'd63, 1'b1, 6'd63, 10'd1023);
    send_cmd(CMD_SPARE7, 7'd127, 6'd63, 1'b1, 6'd63, 10'd1023);
    send_cmd(CMD_CLEAR, 7'd0, 6'd0, 1'b0, 6'd0, 10'd0);
    send_cmd(CMD_READ, 7'd0, 6'd0, 1'b0, 6'd0, 10'd0);
  endtask

  task automatic test_scroll_depths;
    logic [5:0] depth [6] = '{6'd0, 6'd1, 6'd7, 6'd8, 6'd15, 6'd63};
    foreach (depth[k]) begin
      repeat (12) send_cmd(CMD_DRAW, 7'($urandom()), 6'($urandom()), 1'b1, 6'd0, 10'd0);
      send_cmd(CMD_DOWN, 7'd0, 6'd0, 1'b0, depth[k], 10'd0);
      repeat (6) send_cmd(CMD_READ, 7'd0, 6'd0, 1'b0, 6'd0, 10'($urandom()));
    end
  endtask

  task automatic test_random(logic [1:0] m, int count);
    write_mode(m);
    steady = 1'b1;
    repeat (count / 4) send_random();
    steady = 1'b0;
    repeat (count / 4) send_random();
    // hold new work until the pipeline is empty
    drain();
    repeat (count / 2) send_random();
  endtask

  initial begin
    foreach (frame_img[k]) frame_img[k] = '0;
    mode_reg = MODE_2X2;
    last_addr = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed(MODE_2X2);
    test_directed(MODE_1X1);
    test_scroll_depths();
    test_random(MODE_2X1, 420);
    test_random(MODE_1X1, 420);
    test_random(MODE_SPARE, 400);
    test_random(MODE_2X2, 420);
    drain();
    repeat (60) @(posedge clk);
    $display("sent %0d commands (%0d draws, %0d scrolls), checked %0d results",
             sent, draws, scrolls, checked);
    $display("modes 2x2, 2x1, 1x1 and spare, %0d cycles", cycles);
    if (mismatches == 0 && strays == 0 && want_q.size() == 0) begin
      $display("paged_framebuffer_xor_scroll regression: pass");
    end else begin
      $display("paged_framebuffer_xor_scroll regression: fail");
    end
    $finish;
  end
endmodule
